// File: rtl/core/zcws_pkg.sv
// ============================================================================
// zcws_pkg
// Shared constants for the zero-crossing window statistics unit.
// ============================================================================
package zcws_pkg;

    // Configuration register
    localparam int unsigned CFG_BITS = 16;
    localparam logic [CFG_BITS-1:0] MIN_WINDOW_RESET = 16'd10;

    // Accumulator, sample counter and crossing counter width
    localparam int unsigned ACC_BITS = 32;

endpackage

// File: rtl/core/zero_crossing_window_stats_unit.sv
// ============================================================================
// zero_crossing_window_stats_unit
// Segments a sample stream at rising zero crossings and reports window stats.
// ============================================================================
// A sample that does not close a window leaves the unit idle, so the next
// sample can be taken right behind it. A sample that closes a window
// (a negative sample followed by a non-negative one, once the window holds
// at least min_window samples) starts a bit-serial restoring divider that
// forms the window mean one quotient bit per clock: the input is then held
// off for the 32 divide steps and for the state that saturates the mean and
// hands the result to the output register. The hand-off waits while an
// earlier result still sits unread in the output register.
// The output register decouples the two channels; a new sample is taken
// while an earlier result still waits on the output. The configuration port
// is always ready and must only be written while the unit is idle.
module zero_crossing_window_stats_unit #(
    parameter int unsigned MAX_WINDOW  = 65535,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [zcws_pkg::CFG_BITS-1:0]         i_cfg_min_window,

    // Sample input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,

    // Result output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [zcws_pkg::ACC_BITS-1:0]         o_crossing_index,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_after,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_before,
    output logic [SAMPLE_BITS-2:0]                o_window_peak,
    output logic [SAMPLE_BITS-2:0]                o_window_mean,
    output logic [SAMPLE_BITS-2:0]                o_overall_peak,
    output logic [zcws_pkg::ACC_BITS-1:0]         o_crossing_count
);

    localparam int unsigned AW     = SAMPLE_BITS - 1;            // magnitude width
    localparam int unsigned SW     = zcws_pkg::ACC_BITS;         // sum/counter width
    localparam int unsigned CW     = $clog2(MAX_WINDOW + 1);     // window count width
    localparam int unsigned CMPW   = zcws_pkg::CFG_BITS + 1;     // compare width
    localparam int unsigned STEPW  = $clog2(SW);                 // divide step counter

    localparam logic [AW-1:0]         AbsMax   = '1;
    localparam logic [SAMPLE_BITS-1:0] SmpMin  = {1'b1, {AW{1'b0}}};
    localparam logic [CW-1:0]         WinMax   = CW'(MAX_WINDOW);
    localparam logic [STEPW-1:0]      LastStep = STEPW'(SW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration and running state
    logic [zcws_pkg::CFG_BITS-1:0]  r_min_window;
    logic signed [SAMPLE_BITS-1:0]  r_prev;
    logic [CW-1:0]                  r_win_cnt;
    logic [SW-1:0]                  r_win_sum;
    logic [AW-1:0]                  r_win_peak;
    logic [SW-1:0]                  r_sample_cnt;
    logic [AW-1:0]                  r_glob_peak;
    logic [SW-1:0]                  r_cross_cnt;

    // Pending result, held while the mean is divided out
    logic [SW-1:0]                  r_pnd_index;
    logic [SAMPLE_BITS-1:0]         r_pnd_after;
    logic [SAMPLE_BITS-1:0]         r_pnd_before;
    logic [AW-1:0]                  r_pnd_wpeak;
    logic [AW-1:0]                  r_pnd_gpeak;
    logic [SW-1:0]                  r_pnd_count;

    // Bit-serial divider: dividend shifts out as quotient shifts in
    logic [SW-1:0]                  r_quo;
    logic [CW-1:0]                  r_rem;
    logic [CW-1:0]                  r_div;
    logic [STEPW-1:0]               r_step;

    // Output register
    logic                           r_out_valid;
    logic [SW-1:0]                  r_out_index;
    logic [SAMPLE_BITS-1:0]         r_out_after;
    logic [SAMPLE_BITS-1:0]         r_out_before;
    logic [AW-1:0]                  r_out_wpeak;
    logic [AW-1:0]                  r_out_mean;
    logic [AW-1:0]                  r_out_gpeak;
    logic [SW-1:0]                  r_out_count;

    logic                           in_beat;
    logic                           out_free;
    logic [AW-1:0]                  n_abs;
    logic [AW-1:0]                  n_peak;
    logic [SW:0]                    sum_ext;
    logic [SW-1:0]                  n_sum;
    logic [SW-1:0]                  n_sample_cnt;
    logic                           n_cross;
    logic [AW-1:0]                  n_gpeak;
    logic [CW:0]                    rem_sh;
    logic                           q_bit;
    logic [CW-1:0]                  n_rem;
    logic [AW-1:0]                  n_mean;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Per-sample datapath: magnitude, window and overall peak, saturating sum, sample count, crossing test
    always_comb begin
        if (!i_sample[SAMPLE_BITS-1]) begin
            n_abs = i_sample[AW-1:0];
        end else if (i_sample == SmpMin) begin
            n_abs = AbsMax;
        end else begin
            n_abs = AW'(~i_sample + 1'b1);
        end
        n_peak       = (n_abs > r_win_peak) ? n_abs : r_win_peak;
        sum_ext      = {1'b0, r_win_sum} + (SW + 1)'(n_abs);
        n_sum        = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
        n_sample_cnt = r_sample_cnt + 1'b1;
        n_cross      = (CMPW'(r_win_cnt) + 1'b1 >= CMPW'(r_min_window))
                       && r_prev[SAMPLE_BITS-1] && !i_sample[SAMPLE_BITS-1];
        n_gpeak      = (n_peak > r_glob_peak) ? n_peak : r_glob_peak;
    end

    // One restoring divide step, plus mean saturation
    always_comb begin
        rem_sh = {r_rem, r_quo[SW-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
        n_rem  = q_bit ? CW'(rem_sh - {1'b0, r_div}) : rem_sh[CW-1:0];
        n_mean = (|r_quo[SW-1:AW]) ? AbsMax : r_quo[AW-1:0];
    end

    // State, datapath and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_window <= zcws_pkg::MIN_WINDOW_RESET;
            r_prev       <= '0;
            r_win_cnt    <= '0;
            r_win_sum    <= '0;
            r_win_peak   <= '0;
            r_sample_cnt <= '0;
            r_glob_peak  <= '0;
            r_cross_cnt  <= '0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_min_window <= i_cfg_min_window;
            end

            // beat taken; a hand-off in S_DONE refills the register instead
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_prev       <= i_sample;
                        r_sample_cnt <= n_sample_cnt;
                        if (n_cross) begin
                            // close the window and start the mean division
                            r_glob_peak  <= n_gpeak;
                            r_cross_cnt  <= r_cross_cnt + 1'b1;
                            r_pnd_index  <= n_sample_cnt;
                            r_pnd_after  <= i_sample;
                            r_pnd_before <= r_prev;
                            r_pnd_wpeak  <= n_peak;
                            r_pnd_gpeak  <= n_gpeak;
                            r_pnd_count  <= r_cross_cnt + 1'b1;
                            r_quo        <= n_sum;
                            r_rem        <= '0;
                            r_div        <= (r_win_cnt == '0) ? CW'(1) : r_win_cnt;
                            r_step       <= '0;
                            r_win_peak   <= '0;
                            r_win_sum    <= '0;
                            r_win_cnt    <= CW'(1);
                            r_state      <= S_DIV;
                        end else begin
                            r_win_peak <= n_peak;
                            r_win_sum  <= n_sum;
                            if (r_win_cnt < WinMax) begin
                                r_win_cnt <= r_win_cnt + 1'b1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_quo  <= {r_quo[SW-2:0], q_bit};
                    r_rem  <= n_rem;
                    r_step <= r_step + 1'b1;
                    if (r_step == LastStep) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand off once the output register is free
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_index  <= r_pnd_index;
                        r_out_after  <= r_pnd_after;
                        r_out_before <= r_pnd_before;
                        r_out_wpeak  <= r_pnd_wpeak;
                        r_out_mean   <= n_mean;
                        r_out_gpeak  <= r_pnd_gpeak;
                        r_out_count  <= r_pnd_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_crossing_index = r_out_index;
    assign o_sample_after   = r_out_after;
    assign o_sample_before  = r_out_before;
    assign o_window_peak    = r_out_wpeak;
    assign o_window_mean    = r_out_mean;
    assign o_overall_peak   = r_out_gpeak;
    assign o_crossing_count = r_out_count;

endmodule
